[rtl/bvm_pkg.sv]
// Shared types, constants and register codes for the battery voltage monitor.
`default_nettype none
package bvm_pkg;

    // Field widths
    localparam int PinW    = 12;
    localparam int TimeW   = 32;
    localparam int MvW     = 16;
    localparam int NumW    = 8;
    localparam int DenW    = 8;
    localparam int PptW    = 11;
    localparam int CfgIdxW = 4;
    localparam int CfgDatW = 32;

    // Smoothing
    localparam int EmaShift = 4;
    localparam int AccW     = MvW + EmaShift;

    // Conversion datapath
    localparam int PartW    = PinW + NumW;            // pin * num
    localparam int ProdW    = PartW + PptW;           // pin * num * ppt
    localparam int ThouW    = 10;
    localparam logic [ThouW-1:0] Thousand = ThouW'(1000);
    localparam int BotW     = DenW + ThouW;           // den * 1000
    localparam int DvdW     = 32;
    localparam int DivCntW  = $clog2(DvdW);

    // Register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DIVIDER_NUM   = 4'd0,
        CFG_DIVIDER_DEN   = 4'd1,
        CFG_CAL_PPT       = 4'd2,
        CFG_PLAUS_LOW     = 4'd3,
        CFG_PLAUS_HIGH    = 4'd4,
        CFG_WARN_LEVEL    = 4'd5,
        CFG_WARN_HYST     = 4'd6,
        CFG_WARN_DELAY    = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [NumW-1:0]  divider_num;
        logic [DenW-1:0]  divider_den;
        logic [PptW-1:0]  calibration_ppt;
        logic [MvW-1:0]   plausible_low_mv;
        logic [MvW-1:0]   plausible_high_mv;
        logic [MvW-1:0]   warn_level_mv;
        logic [MvW-1:0]   warn_hysteresis_mv;
        logic [TimeW-1:0] warn_delay_ms;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        divider_num:        NumW'(11),
        divider_den:        DenW'(1),
        calibration_ppt:    PptW'(1000),
        plausible_low_mv:   MvW'(2500),
        plausible_high_mv:  MvW'(30000),
        warn_level_mv:      MvW'(6600),
        warn_hysteresis_mv: MvW'(200),
        warn_delay_ms:      TimeW'(2000)
    };

    // Step strobes from the sequencer into the tracker
    typedef struct packed {
        logic ema;
        logic warn;
    } t_trk_ctl;

endpackage
`default_nettype wire

[rtl/battery_voltage_monitor_top.sv]
// Top level of the battery voltage monitor: sequencer, scaling datapath and result register.
`default_nettype none
// Each input beat (sense-pin millivolts plus a wrapping millisecond timestamp) is
// scaled to battery millivolts as pin*num*ppt/(den*1000), rounded half up and
// saturated at 65535, then either unseeds the smoothed average (implausible
// reading) or seeds/updates a 1/16 exponential average. A low warning latches
// after warn_delay_ms of continuous low average and clears once the average
// rises above warn level plus hysteresis; a sustained implausible reading
// drops it too. One result beat comes out per input beat. The block works on
// one sample at a time, through the multiply states MUL1 and MUL2, the rounding
// state RND, the serial divider, which gives one quotient bit per cycle over a
// 32-bit dividend, the tracking states EMA and WARN and the result load in EMIT.
// The next sample can be taken once the result has loaded. o_in_stall stays
// high while a sample is in flight. The result register holds a finished beat
// while the next sample is being taken and worked on; the sequencer only
// waits at the very end if that beat has still not been taken. Configuration
// writes are always ready and must only be issued while the block is idle;
// writes to an index beyond the register list are dropped.
module battery_voltage_monitor_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Sample channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [bvm_pkg::PinW-1:0]     i_pin_mv,
    input  wire  [bvm_pkg::TimeW-1:0]    i_now_ms,
    // Result channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [bvm_pkg::MvW-1:0]      o_battery_mv,
    output logic                         o_low_warning,
    output logic                         o_reading_implausible,
    // Configuration write channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [bvm_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire  [bvm_pkg::CfgDatW-1:0]  i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL1 = 8'b0000_0010,
        S_MUL2 = 8'b0000_0100,
        S_RND  = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_EMA  = 8'b0010_0000,
        S_WARN = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;

    logic [bvm_pkg::PinW-1:0]       r_pin;
    logic [bvm_pkg::TimeW-1:0]      r_now;
    logic [bvm_pkg::PartW-1:0]      r_part;
    logic [bvm_pkg::ProdW-1:0]      r_prod;
    logic [bvm_pkg::BotW-1:0]       r_bot;
    logic [bvm_pkg::MvW-1:0]        r_v;

    logic                           r_out_valid;
    logic [bvm_pkg::MvW-1:0]        r_out_mv;
    logic                           r_out_warn;
    logic                           r_out_imp;

    bvm_pkg::t_cfg                  cfg;
    bvm_pkg::t_trk_ctl              trk_ctl;

    logic                           in_accept;
    logic                           out_free;
    logic                           div_start;
    logic                           div_done;
    logic [bvm_pkg::DvdW-1:0]       div_dvd;
    logic [bvm_pkg::DvdW-1:0]       div_q;

    logic [bvm_pkg::MvW-1:0]        trk_mv;
    logic                           trk_warn;
    logic                           trk_imp;

    assign in_accept = i_in_valid && !o_in_stall;
    // Result register can load when empty or being drained this cycle
    assign out_free  = !r_out_valid || !i_out_stall;

    bvm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_accept) n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_RND;
            S_RND:  n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_EMA;
            S_EMA:  n_state = S_WARN;
            S_WARN: n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // ---------------------------------------------------------------
    // Scaling datapath: two multiply steps, rounding bias, serial divide
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pin <= i_pin_mv;
            r_now <= i_now_ms;
        end
        if (r_state == S_MUL1) begin
            r_part <= bvm_pkg::PartW'(r_pin * cfg.divider_num);
            r_bot  <= bvm_pkg::BotW'(cfg.divider_den * bvm_pkg::Thousand);
        end
        if (r_state == S_MUL2) begin
            r_prod <= bvm_pkg::ProdW'(r_part * cfg.calibration_ppt);
        end
        // Saturate the quotient; a zero divisor yields all ones and saturates too
        if (r_state == S_DIV && div_done) begin
            r_v <= (div_q[bvm_pkg::DvdW-1:bvm_pkg::MvW] != '0) ? '1
                                                             : div_q[bvm_pkg::MvW-1:0];
        end
    end

    assign div_start = (r_state == S_RND);
    assign div_dvd   = bvm_pkg::DvdW'(r_prod) + bvm_pkg::DvdW'(r_bot >> 1);

    bvm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_bot),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // ---------------------------------------------------------------
    // Average and warning state
    // ---------------------------------------------------------------
    assign trk_ctl.ema  = (r_state == S_EMA);
    assign trk_ctl.warn = (r_state == S_WARN);

    bvm_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (trk_ctl),
        .i_cfg     (cfg),
        .i_v       (r_v),
        .i_now     (r_now),
        .o_mv      (trk_mv),
        .o_warn    (trk_warn),
        .o_implaus (trk_imp)
    );

    // ---------------------------------------------------------------
    // Result register: hold a beat until taken
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_mv   <= trk_mv;
            r_out_warn <= trk_warn;
            r_out_imp  <= trk_imp;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_battery_mv          = r_out_mv;
    assign o_low_warning         = r_out_warn;
    assign o_reading_implausible = r_out_imp;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_implaus_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_reading_implausible) |-> (o_battery_mv == '0))
        else $error("implausible result carries a nonzero voltage");

    a_emit_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (o_out_valid && !o_in_stall))
        else $error("finished sample did not reach the result register");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_MUL1))
        else $error("accepted sample did not start the sequence");

endmodule
`default_nettype wire

[rtl/bvm_cfg.sv]
// Configuration register file for the battery voltage monitor.
`default_nettype none
module bvm_cfg (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [bvm_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  wire  [bvm_pkg::CfgDatW-1:0]      i_cfg_data,
    output bvm_pkg::t_cfg                    o_cfg
);

    bvm_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bvm_pkg::CfgReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bvm_pkg::CFG_DIVIDER_NUM: r_cfg.divider_num <= i_cfg_data[bvm_pkg::NumW-1:0];
                bvm_pkg::CFG_DIVIDER_DEN: r_cfg.divider_den <= i_cfg_data[bvm_pkg::DenW-1:0];
                bvm_pkg::CFG_CAL_PPT: r_cfg.calibration_ppt <= i_cfg_data[bvm_pkg::PptW-1:0];
                bvm_pkg::CFG_PLAUS_LOW: r_cfg.plausible_low_mv <= i_cfg_data[bvm_pkg::MvW-1:0];
                bvm_pkg::CFG_PLAUS_HIGH: r_cfg.plausible_high_mv <= i_cfg_data[bvm_pkg::MvW-1:0];
                bvm_pkg::CFG_WARN_LEVEL: r_cfg.warn_level_mv <= i_cfg_data[bvm_pkg::MvW-1:0];
                bvm_pkg::CFG_WARN_HYST: r_cfg.warn_hysteresis_mv <= i_cfg_data[bvm_pkg::MvW-1:0];
                bvm_pkg::CFG_WARN_DELAY: r_cfg.warn_delay_ms <= i_cfg_data[bvm_pkg::TimeW-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/bvm_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module bvm_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [bvm_pkg::DvdW-1:0]     i_dividend,
    input  wire  [bvm_pkg::BotW-1:0]     i_divisor,
    output logic                         o_done,
    output logic [bvm_pkg::DvdW-1:0]     o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [bvm_pkg::DivCntW-1:0]    r_cnt;
    logic [bvm_pkg::BotW-1:0]       r_dvs;
    logic [bvm_pkg::BotW-1:0]       r_rem;
    logic [bvm_pkg::DvdW-1:0]       r_q;

    logic [bvm_pkg::BotW:0]         n_rem_sh;
    logic                           n_fit;

    // Shift in the next dividend bit and try the subtract
    assign n_rem_sh = {r_rem, r_q[bvm_pkg::DvdW-1]};
    assign n_fit    = (n_rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_fit ? bvm_pkg::BotW'(n_rem_sh - {1'b0, r_dvs})
                           : n_rem_sh[bvm_pkg::BotW-1:0];
            r_q   <= {r_q[bvm_pkg::DvdW-2:0], n_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

[rtl/bvm_track.sv]
// Smoothing accumulator, plausibility tracking and low-warning qualification.
`default_nettype none
module bvm_track (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  bvm_pkg::t_trk_ctl      i_ctl,
    input  wire  bvm_pkg::t_cfg          i_cfg,
    input  wire  [bvm_pkg::MvW-1:0]      i_v,
    input  wire  [bvm_pkg::TimeW-1:0]    i_now,
    output logic [bvm_pkg::MvW-1:0]      o_mv,
    output logic                         o_warn,
    output logic                         o_implaus
);

    logic [bvm_pkg::AccW-1:0]   r_acc;
    logic                       r_seeded;
    logic                       r_iflag;
    logic [bvm_pkg::TimeW-1:0]  r_istart;
    logic                       r_pend;
    logic [bvm_pkg::TimeW-1:0]  r_lstart;
    logic                       r_warn;

    logic                       n_implaus;
    logic [bvm_pkg::TimeW-1:0]  n_istart;
    logic                       n_idrop;
    logic [bvm_pkg::AccW:0]     n_acc_upd;
    logic [bvm_pkg::AccW:0]     n_rnd;
    logic [bvm_pkg::AccW-bvm_pkg::EmaShift:0] n_rsh;
    logic [bvm_pkg::MvW-1:0]    n_sm;
    logic [bvm_pkg::MvW:0]      n_clear_lvl;
    logic                       n_ldone;

    assign n_implaus = (i_v < i_cfg.plausible_low_mv) || (i_v > i_cfg.plausible_high_mv);
    assign n_istart  = r_iflag ? r_istart : i_now;
    assign n_idrop   = ((i_now - n_istart) >= i_cfg.warn_delay_ms);

    assign n_acc_upd = (bvm_pkg::AccW+1)'(r_acc) + (bvm_pkg::AccW+1)'(i_v)
                     - (bvm_pkg::AccW+1)'(r_acc >> bvm_pkg::EmaShift);

    // Round half up, saturate the readout
    assign n_rnd = (bvm_pkg::AccW+1)'(r_acc)
                 + (bvm_pkg::AccW+1)'(1 << (bvm_pkg::EmaShift - 1));
    assign n_rsh = n_rnd[bvm_pkg::AccW:bvm_pkg::EmaShift];
    assign n_sm  = n_rsh[bvm_pkg::MvW] ? '1 : n_rsh[bvm_pkg::MvW-1:0];

    assign n_clear_lvl = (bvm_pkg::MvW+1)'(i_cfg.warn_level_mv)
                       + (bvm_pkg::MvW+1)'(i_cfg.warn_hysteresis_mv);
    assign n_ldone     = ((i_now - r_lstart) >= i_cfg.warn_delay_ms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_seeded <= 1'b0;
            r_iflag  <= 1'b0;
            r_pend   <= 1'b0;
            r_warn   <= 1'b0;
        end else if (i_ctl.ema) begin
            if (n_implaus) begin
                r_iflag  <= 1'b1;
                r_seeded <= 1'b0;
                r_acc    <= '0;
                if (n_idrop) begin
                    r_warn <= 1'b0;
                    r_pend <= 1'b0;
                end
            end else begin
                r_iflag  <= 1'b0;
                r_seeded <= 1'b1;
                r_acc    <= r_seeded ? n_acc_upd[bvm_pkg::AccW-1:0]
                                     : (bvm_pkg::AccW'(i_v) << bvm_pkg::EmaShift);
            end
        end else if (i_ctl.warn && !r_iflag) begin
            if (r_warn) begin
                if ({1'b0, n_sm} > n_clear_lvl) begin
                    r_warn <= 1'b0;
                    r_pend <= 1'b0;
                end
            end else if (n_sm < i_cfg.warn_level_mv) begin
                if (!r_pend) begin
                    r_pend <= 1'b1;
                end else if (n_ldone) begin
                    r_warn <= 1'b1;
                end
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    // Start times carry no reset; each is written before it is read
    always_ff @(posedge i_clk) begin
        if (i_ctl.ema && n_implaus && !r_iflag) begin
            r_istart <= i_now;
        end
        if (i_ctl.warn && !r_iflag && !r_warn && !r_pend
                && (n_sm < i_cfg.warn_level_mv)) begin
            r_lstart <= i_now;
        end
    end

    assign o_mv      = r_seeded ? n_sm : '0;
    assign o_warn    = r_warn;
    assign o_implaus = r_iflag;

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for the battery voltage monitor: directed and random sample beats.
module testbench;
    import bvm_pkg::*;

    localparam int HalfPeriod    = 10;
    localparam int ResetCycles   = 9;
    localparam int CycleLimit    = 500000;
    localparam int DrainCycles   = 48;      // a little over one sample's pass through the block
    localparam int HoldOffCycles = 400;
    localparam int MaxSendGap    = 30;
    localparam int RandomItems   = 520;
    localparam int PhaseCount    = 16;
    localparam int PptScale      = 1000;
    localparam int PinMax        = (1 << PinW) - 1;
    localparam logic [MvW-1:0] MvMax = '1;
    localparam int FirstUnusedIdx = int'(CFG_WARN_DELAY) + 1;
    localparam int LastIdx        = (1 << CfgIdxW) - 1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {TGT_LOW, TGT_HIGH, TGT_EDGE, TGT_OUTSIDE, TGT_NOISE} target_class_t;

    typedef struct packed {
        logic [MvW-1:0] battery_mv;
        logic           low_warning;
        logic           reading_implausible;
    } reading_t;

    // DUT ports; the inputs are driven to known values from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [PinW-1:0]     i_pin_mv    = '0;
    logic [TimeW-1:0]    i_now_ms    = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [MvW-1:0]      o_battery_mv;
    logic                o_low_warning;
    logic                o_reading_implausible;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDatW-1:0]  i_cfg_data  = '0;

    // Predictor copy of the register file and of the monitor state
    t_cfg model_cfg = '{
        divider_num:        NumW'(11),
        divider_den:        DenW'(1),
        calibration_ppt:    PptW'(1000),
        plausible_low_mv:   MvW'(2500),
        plausible_high_mv:  MvW'(30000),
        warn_level_mv:      MvW'(6600),
        warn_hysteresis_mv: MvW'(200),
        warn_delay_ms:      TimeW'(2000)
    };
    logic [31:0]      ema_acc           = '0;
    bit               seeded            = 1'b0;
    bit               implausible       = 1'b0;
    bit               low_pending       = 1'b0;
    bit               warn_latched      = 1'b0;
    logic [TimeW-1:0] implausible_since = '0;
    logic [TimeW-1:0] low_since         = '0;

    reading_t         expected_readings[$];
    int               mismatches      = 0;
    int               items_sent      = 0;
    int               send_idle_pct   = 0;
    int               recv_stall_pct  = 0;
    int               out_hold_left   = 0;
    int unsigned      cycle_count     = 0;
    logic [TimeW-1:0] sample_clock_ms = '0;

    battery_voltage_monitor_top dut (.*);

    always begin
        #HalfPeriod i_clk = 1'b1;
        #HalfPeriod i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // Pin millivolts to battery millivolts, rounded half up, saturated.
    function automatic logic [MvW-1:0] scale_to_mv(logic [PinW-1:0] pin);
        logic [63:0] numer, denom, q;
        numer = 64'(pin) * 64'(model_cfg.divider_num) * 64'(model_cfg.calibration_ppt);
        denom = 64'(model_cfg.divider_den) * 64'(PptScale);
        if (denom == 0)
            return MvMax;
        q = (numer + denom / 2) / denom;
        return (q > 64'(MvMax)) ? MvMax : q[MvW-1:0];
    endfunction

    function automatic logic [MvW-1:0] smoothed_mv();
        logic [31:0] r;
        if (!seeded)
            return '0;
        r = (ema_acc + (32'd1 << (EmaShift - 1))) >> EmaShift;
        return (r > 32'(MvMax)) ? MvMax : r[MvW-1:0];
    endfunction

    // Advance the monitor state by one sample and return the reading it publishes.
    function automatic reading_t predict_reading(logic [PinW-1:0] pin, logic [TimeW-1:0] now);
        logic [MvW-1:0]   v, sm;
        logic [TimeW-1:0] elapsed;
        reading_t         r;
        v = scale_to_mv(pin);
        if (v < model_cfg.plausible_low_mv || v > model_cfg.plausible_high_mv) begin
            if (!implausible) begin
                implausible       = 1'b1;
                implausible_since = now;
            end
            seeded  = 1'b0;
            ema_acc = '0;
            elapsed = now - implausible_since;
            // a long enough run of bad readings drops the warning as well
            if (elapsed >= model_cfg.warn_delay_ms) begin
                warn_latched = 1'b0;
                low_pending  = 1'b0;
            end
        end else begin
            implausible = 1'b0;
            if (!seeded) begin
                ema_acc = 32'(v) << EmaShift;
                seeded  = 1'b1;
            end else begin
                ema_acc = ema_acc + 32'(v) - (ema_acc >> EmaShift);
            end
            sm = smoothed_mv();
            if (warn_latched) begin
                // clear threshold is formed at 17 bits so it never wraps
                if ({1'b0, sm} > {1'b0, model_cfg.warn_level_mv}
                                 + {1'b0, model_cfg.warn_hysteresis_mv}) begin
                    warn_latched = 1'b0;
                    low_pending  = 1'b0;
                end
            end else if (sm < model_cfg.warn_level_mv) begin
                if (!low_pending) begin
                    low_pending = 1'b1;
                    low_since   = now;
                end else begin
                    elapsed = now - low_since;
                    if (elapsed >= model_cfg.warn_delay_ms)
                        warn_latched = 1'b1;
                end
            end else begin
                low_pending = 1'b0;
            end
        end
        r.battery_mv          = smoothed_mv();
        r.low_warning         = warn_latched;
        r.reading_implausible = implausible;
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 70; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            IDLE_BOTH:     begin send_idle_pct = 24; recv_stall_pct = 24; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Write one register and mirror it, masked to its width, into the predictor.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DIVIDER_NUM: model_cfg.divider_num        = data[NumW-1:0];
            CFG_DIVIDER_DEN: model_cfg.divider_den        = data[DenW-1:0];
            CFG_CAL_PPT:     model_cfg.calibration_ppt    = data[PptW-1:0];
            CFG_PLAUS_LOW:   model_cfg.plausible_low_mv   = data[MvW-1:0];
            CFG_PLAUS_HIGH:  model_cfg.plausible_high_mv  = data[MvW-1:0];
            CFG_WARN_LEVEL:  model_cfg.warn_level_mv      = data[MvW-1:0];
            CFG_WARN_HYST:   model_cfg.warn_hysteresis_mv = data[MvW-1:0];
            CFG_WARN_DELAY:  model_cfg.warn_delay_ms      = data[TimeW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Fill the bits above the register width with noise; the block must drop them.
    function automatic logic [CfgDatW-1:0] junk_above(int width, logic [CfgDatW-1:0] value);
        logic [CfgDatW-1:0] mask;
        mask = (width >= CfgDatW) ? '1 : ((CfgDatW'(1) << width) - 1);
        return (CfgDatW'($urandom) & ~mask) | (value & mask);
    endfunction

    // Offer one sample beat after an optional idle gap; valid stays high after
    // acceptance so that back-to-back beats need no idle gap.
    task automatic send_sample(logic [PinW-1:0] pin, logic [TimeW-1:0] now);
        int gap;
        gap = 0;
        while (gap < MaxSendGap && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_pin_mv   <= pin;
        i_now_ms   <= now;
        do @(posedge i_clk); while (o_in_stall);
        expected_readings.push_back(predict_reading(pin, now));
        items_sent++;
    endtask

    // Drop valid and hold until every expected beat has come out.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: a long hold-off when one is armed, otherwise random stalls.
    always @(negedge i_clk) begin
        if (out_hold_left > 0) begin
            i_out_stall   <= 1'b1;
            out_hold_left <= out_hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare every accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin : check_reading
        reading_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result beat: mv %0d warning %0b implausible %0b",
                         $time, o_battery_mv, o_low_warning, o_reading_implausible);
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                if (o_battery_mv !== want.battery_mv) begin
                    $display("%0t: battery_mv expected %0d, got %0d",
                             $time, want.battery_mv, o_battery_mv);
                    mismatches++;
                end
                if (o_low_warning !== want.low_warning) begin
                    $display("%0t: low_warning expected %0b, got %0b",
                             $time, want.low_warning, o_low_warning);
                    mismatches++;
                end
                if (o_reading_implausible !== want.reading_implausible) begin
                    $display("%0t: reading_implausible expected %0b, got %0b",
                             $time, want.reading_implausible, o_reading_implausible);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    // Pin value whose scaled reading lands near the target millivolts.
    function automatic logic [PinW-1:0] pin_for_mv(int unsigned target);
        logic [63:0] gain, p;
        gain = 64'(model_cfg.divider_num) * 64'(model_cfg.calibration_ppt);
        if (gain == 0)
            return PinW'($urandom);
        p = (64'(target) * 64'(model_cfg.divider_den) * 64'(PptScale) + gain / 2) / gain;
        return (p > 64'(PinMax)) ? PinW'(PinMax) : p[PinW-1:0];
    endfunction

    function automatic int unsigned pick_target(target_class_t cls);
        int unsigned lo, hi, lvl, clr;
        lo  = model_cfg.plausible_low_mv;
        hi  = model_cfg.plausible_high_mv;
        lvl = model_cfg.warn_level_mv;
        clr = lvl + model_cfg.warn_hysteresis_mv;
        case (cls)
            TGT_LOW:  return $urandom_range(lo, lvl);
            TGT_HIGH: return $urandom_range(clr, hi);
            TGT_EDGE: return ($urandom_range(1) ? lvl : clr) + $urandom_range(2);
            default:  return $urandom_range(1) ? $urandom_range(0, lo)
                                               : $urandom_range(hi, int'(MvMax));
        endcase
    endfunction

    // Next timestamp: mostly small steps, sometimes right on a qualification
    // boundary, sometimes a jump that wraps the millisecond counter.
    function automatic logic [TimeW-1:0] next_sample_time();
        logic [TimeW-1:0] d, base;
        d = model_cfg.warn_delay_ms;
        case ($urandom_range(15))
            0: begin
                base = low_pending ? low_since
                                   : (implausible ? implausible_since : sample_clock_ms);
                return base + d + $urandom_range(2) - 1;
            end
            1:       return sample_clock_ms + $urandom;
            default: return sample_clock_ms + $urandom_range(0, d / 3 + 3);
        endcase
    endfunction

    // One run of samples: a steady level with random content, or noise.
    task automatic run_sequence();
        target_class_t   cls;
        int unsigned     target;
        int              len;
        logic [PinW-1:0] pin;
        case ($urandom_range(9))
            0, 1, 2: cls = TGT_LOW;
            3, 4:    cls = TGT_HIGH;
            5:       cls = TGT_EDGE;
            6, 7:    cls = TGT_OUTSIDE;
            default: cls = TGT_NOISE;
        endcase
        len    = $urandom_range(3, 16);
        target = pick_target(cls);
        for (int i = 0; i < len; i++) begin
            if (cls == TGT_NOISE) begin
                pin = PinW'($urandom);
                sample_clock_ms = $urandom_range(1) ? TimeW'($urandom) : next_sample_time();
            end else begin
                pin = pin_for_mv(target) ^ PinW'($urandom_range(1));
                sample_clock_ms = next_sample_time();
            end
            send_sample(pin, sample_clock_ms);
        end
    endtask

    // Pick a fresh register set; extreme sets hit saturation and degenerate
    // corners of the conversion, band, hysteresis and delay registers.
    task automatic randomize_config(bit extreme);
        logic [NumW-1:0]  num;
        logic [DenW-1:0]  den;
        logic [PptW-1:0]  ppt;
        logic [MvW-1:0]   span, lo, hi, lvl, hyst;
        logic [TimeW-1:0] delay;
        num = $urandom_range(1, 255);
        den = $urandom_range(1, 255);
        ppt = $urandom_range(900, 1100);
        if (extreme) begin
            case ($urandom_range(3))
                0: den = '0;
                1: ppt = $urandom_range(1) ? '0 : '1;
                2: begin num = '1; den = DenW'(1); end
                default: num = '0;
            endcase
        end
        write_reg(CFG_DIVIDER_NUM, junk_above(NumW, num));
        write_reg(CFG_DIVIDER_DEN, junk_above(DenW, den));
        write_reg(CFG_CAL_PPT, junk_above(PptW, ppt));
        span  = scale_to_mv(PinW'(PinMax));
        lo    = $urandom_range(0, span / 4);
        hi    = $urandom_range(span / 2, span);
        lvl   = $urandom_range(lo, hi);
        hyst  = $urandom_range(0, span / 8);
        delay = $urandom_range(0, 300);
        if (extreme) begin
            case ($urandom_range(2))
                0: begin lo = '0; hi = '1; end
                1: begin lo = hi; hi = span / 4; end      // inverted band
                default: ;
            endcase
            hyst  = $urandom_range(1) ? '1 : '0;
            delay = $urandom_range(1) ? TimeW'($urandom) : ($urandom_range(1) ? '1 : '0);
        end
        write_reg(CFG_PLAUS_LOW, junk_above(MvW, lo));
        write_reg(CFG_PLAUS_HIGH, junk_above(MvW, hi));
        write_reg(CFG_WARN_LEVEL, junk_above(MvW, lvl));
        write_reg(CFG_WARN_HYST, junk_above(MvW, hyst));
        write_reg(CFG_WARN_DELAY, delay);
        if ($urandom_range(3) == 0)
            write_reg(CfgIdxW'($urandom_range(FirstUnusedIdx, LastIdx)), $urandom);
    endtask

    // ---------------------------------------------------------------- tests

    // Reset registers: implausible extremes with a wrapped timestamp, low
    // qualification one ms short and then on time, recovery past the
    // hysteresis, and a sustained bad reading dropping a latched warning.
    task automatic test_default_warning_cycle();
        send_sample(PinW'(0), TimeW'(0));
        send_sample('1, '1);
        send_sample(PinW'(300), TimeW'(10));
        send_sample(PinW'(300), TimeW'(2009));
        send_sample(PinW'(300), TimeW'(2010));
        for (int i = 0; i < 3; i++)
            send_sample(PinW'(2727), TimeW'(2100 + 100 * i));
        send_sample(PinW'(0), TimeW'(2500));
        send_sample(PinW'(300), TimeW'(2600));
        send_sample(PinW'(300), TimeW'(4600));
        send_sample(PinW'(0), TimeW'(4700));
        send_sample('1, TimeW'(6699));
        send_sample('1, TimeW'(6700));
        wait_idle();
    endtask

    // Register corners: exact plausibility bounds with zero delay, zero
    // denominator, conversion overflow, 17-bit clear threshold, masked data
    // and writes past the register list.
    task automatic test_register_extremes();
        write_reg(CFG_DIVIDER_NUM, junk_above(NumW, 1));
        write_reg(CFG_DIVIDER_DEN, junk_above(DenW, 1));
        write_reg(CFG_CAL_PPT, junk_above(PptW, 1000));
        write_reg(CFG_PLAUS_LOW, junk_above(MvW, 1000));
        write_reg(CFG_PLAUS_HIGH, junk_above(MvW, 3000));
        write_reg(CFG_WARN_LEVEL, junk_above(MvW, 2000));
        write_reg(CFG_WARN_HYST, junk_above(MvW, 0));
        write_reg(CFG_WARN_DELAY, '0);
        send_sample(PinW'(999), TimeW'(100));
        send_sample(PinW'(1000), TimeW'(101));
        send_sample(PinW'(1000), TimeW'(101));
        send_sample(PinW'(3000), TimeW'(102));
        send_sample(PinW'(3001), TimeW'(103));
        send_sample(PinW'(3000), TimeW'(104));
        wait_idle();

        write_reg(CFG_DIVIDER_DEN, junk_above(DenW, 0));
        write_reg(CFG_DIVIDER_NUM, '1);
        write_reg(CFG_CAL_PPT, '1);
        write_reg(CFG_PLAUS_LOW, junk_above(MvW, 0));
        write_reg(CFG_PLAUS_HIGH, '1);
        write_reg(CFG_WARN_LEVEL, '1);
        write_reg(CFG_WARN_HYST, '1);
        write_reg(CFG_WARN_DELAY, '1);
        send_sample('1, TimeW'(0));
        send_sample(PinW'(0), TimeW'(1));
        wait_idle();

        write_reg(CFG_DIVIDER_DEN, junk_above(DenW, 1));
        send_sample(PinW'(1), TimeW'(2));
        send_sample('1, TimeW'(3));
        wait_idle();

        // with the clear threshold out of reach the warning must stay latched
        write_reg(CFG_WARN_DELAY, '0);
        send_sample(PinW'(0), TimeW'(4));
        send_sample(PinW'(0), TimeW'(5));
        wait_idle();

        write_reg(CfgIdxW'(FirstUnusedIdx), $urandom);
        write_reg(CfgIdxW'(LastIdx), '1);
        send_sample('1, TimeW'(6));
        wait_idle();
    endtask

    // Hold the result channel off long enough that the block backs up and
    // stalls its sample input while beats keep being offered.
    task automatic test_result_backpressure();
        set_idling(IDLE_NONE);
        @(posedge i_clk);
        out_hold_left = HoldOffCycles;
        for (int i = 0; i < 8; i++) begin
            sample_clock_ms = sample_clock_ms + 150;
            send_sample(PinW'($urandom_range(300, 2700)), sample_clock_ms);
        end
        wait_idle();
    endtask

    // Phases of random sequences, each with its own registers and idling.
    task automatic test_random_traffic();
        int phase_goal;
        sample_clock_ms = $urandom;
        for (int phase = 0; phase < PhaseCount; phase++) begin
            wait_idle();
            set_idling(idle_mode_t'(phase % 4));
            randomize_config(phase % 3 == 2);
            phase_goal = items_sent + RandomItems / PhaseCount;
            while (items_sent < phase_goal)
                run_sequence();
        end
        wait_idle();
    endtask

    initial begin
        set_idling(IDLE_NONE);
        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_warning_cycle();
        test_register_extremes();
        test_result_backpressure();
        test_random_traffic();

        // let any stray beat show up before the verdict
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
